// ----- rtl/mmnp_pkg.sv -----
// shared types, constants and pitch table for the music macro note parser
package mmnp_pkg;

  typedef struct packed {
    logic [7:0] score_char;
    logic       end_of_score;
  } in_item_t;

  typedef struct packed {
    logic [13:0] freq_hz;
    logic [14:0] duration_ms;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_OCT  = 3'd1,
    PH_LEN  = 3'd2,
    PH_TMP  = 3'd3,
    PH_ACC  = 3'd4,
    PH_NUM  = 3'd5,
    PH_DOTS = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_NOTE = 2'd1,
    PK_REST = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PARSE = 3'd1,
    ST_DIV   = 3'd2,
    ST_DOTS  = 3'd3,
    ST_EMIT  = 3'd4
  } state_e;

  // note job handed to the duration/pitch unit
  typedef struct packed {
    logic        is_note;
    logic [3:0]  semi;
    logic [3:0]  octp1;
    logic [6:0]  len;
    logic [9:0]  tempo;
    logic [3:0]  dots;
  } note_job_t;

  localparam logic [17:0] DIVIDEND = 18'd240000;

  function automatic logic [28:0] pitch_q20(input logic [3:0] s);
    unique case (s)
      4'd0:  pitch_q20 = 29'd274334289;
      4'd1:  pitch_q20 = 29'd290647054;
      4'd2:  pitch_q20 = 29'd307929828;
      4'd3:  pitch_q20 = 29'd326240288;
      4'd4:  pitch_q20 = 29'd345639545;
      4'd5:  pitch_q20 = 29'd366192342;
      4'd6:  pitch_q20 = 29'd387967272;
      4'd7:  pitch_q20 = 29'd411037006;
      4'd8:  pitch_q20 = 29'd435478539;
      4'd9:  pitch_q20 = 29'd461373440;
      4'd10: pitch_q20 = 29'd488808132;
      4'd11: pitch_q20 = 29'd517874176;
      default: pitch_q20 = 29'd274334289;
    endcase
  endfunction

  function automatic logic [3:0] letter_semi(input logic [2:0] l);
    unique case (l)
      3'd0: letter_semi = 4'd9;
      3'd1: letter_semi = 4'd11;
      3'd2: letter_semi = 4'd0;
      3'd3: letter_semi = 4'd2;
      3'd4: letter_semi = 4'd4;
      3'd5: letter_semi = 4'd5;
      3'd6: letter_semi = 4'd7;
      default: letter_semi = 4'd0;
    endcase
  endfunction

endpackage

// ----- rtl/mmnp_note_unit.sv -----
// serial divider and dot accumulator computing one note's frequency and duration
module mmnp_note_unit import mmnp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  note_job_t   job_i,
  output logic        done_o,
  output logic [13:0] freq_o,
  output logic [14:0] dur_o
);

  logic [16:0] div_q, div_d;     // tempo*len, at most 65472
  logic [17:0] quo_q, quo_d;     // dividend shifts out as quotient shifts in
  logic [16:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [3:0]  dots_q, dots_d;
  logic [17:0] ms_q, ms_d;
  logic [17:0] add_q, add_d;
  logic        busy_q, busy_d, div_phase_q, div_phase_d;
  logic [13:0] freq_q, freq_d;
  logic [17:0] rtrial;
  logic [16:0] product;
  logic [29:0] rounded;

  assign product = 17'(job_i.tempo) * 17'(job_i.len);
  assign rtrial  = {rem_q, quo_q[17]};

  always_comb begin
    logic [3:0] sh;
    sh = 4'd0;
    rounded = 30'd0;
    if (job_i.octp1 >= 4'd5) begin
      sh = job_i.octp1 - 4'd5;
      rounded = 30'((({8'd0, pitch_q20(job_i.semi)} << sh) + 37'd524288) >> 20);
    end else begin
      sh = 4'd5 - job_i.octp1;
      rounded = 30'((({8'd0, pitch_q20(job_i.semi)} + (37'd524288 << sh)) >> 20) >> sh);
    end
  end

  always_comb begin
    div_d = div_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    dots_d = dots_q; ms_d = ms_q; add_d = add_q; busy_d = busy_q;
    div_phase_d = div_phase_q; freq_d = freq_q; done_o = 1'b0;
    if (start_i) begin
      div_d = product; quo_d = DIVIDEND; rem_d = '0; cnt_d = 5'd18;
      dots_d = job_i.dots; busy_d = 1'b1; div_phase_d = 1'b1;
      freq_d = job_i.is_note ? rounded[13:0] : 14'd0;
    end else if (busy_q && div_phase_q) begin
      if (rtrial >= {1'b0, div_q}) begin
        rem_d = 17'(rtrial - {1'b0, div_q});
        quo_d = {quo_q[16:0], 1'b1};
      end else begin
        rem_d = rtrial[16:0];
        quo_d = {quo_q[16:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        div_phase_d = 1'b0;
        ms_d = quo_d;
        add_d = quo_d >> 1;
      end
    end else if (busy_q) begin
      if (dots_q != 4'd0) begin
        ms_d = ms_q + add_q;
        add_d = add_q >> 1;
        dots_d = dots_q - 4'd1;
      end else begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign freq_o = freq_q;
  assign dur_o  = ms_q[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_phase_q <= 1'b0;
      cnt_q <= '0;
      dots_q <= '0;
    end else begin
      busy_q <= busy_d;
      div_phase_q <= div_phase_d;
      cnt_q <= cnt_d;
      dots_q <= dots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d; quo_q <= quo_d; rem_q <= rem_d;
    ms_q <= ms_d; add_q <= add_d; freq_q <= freq_d;
  end

endmodule

// ----- rtl/music_macro_note_parser.sv -----
// top level: character parser, note queue and handshake
// throughput: one character at a time; a character with no note returns to idle after parsing,
// each note passes through start, restoring division, one accumulation step per dot, finish and emit
// the division unit is the limiting resource; a held output stalls the next character
// reset: asynchronous active low, octave 4, length 4, tempo 120, nothing pending
module music_macro_note_parser import mmnp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  state_e state_q, state_d;
  in_item_t ch_q;
  phase_e ph_q, ph_d;
  kind_e kind_q, kind_d;
  logic [3:0] semi_q, semi_d, poct_q, poct_d, dot_q, dot_d;
  logic [15:0] acc_q, acc_d;
  logic seen_q, seen_d;
  logic [3:0] oct_q, oct_d;
  logic [6:0] dlen_q, dlen_d;
  logic [9:0] tempo_q, tempo_d;
  note_job_t [1:0] jobs_d, jobs_q;
  logic [1:0] njobs_d, njobs_q, jidx_q, jidx_d;
  logic out_v_q, out_v_d;
  out_item_t out_q, out_d;
  logic start, done;
  logic [13:0] fr;
  logic [14:0] du;

  // combinational parse of one character
  always_comb begin
    logic [7:0] c, u;
    logic dig, ext, cont;
    logic [19:0] v;
    logic [6:0] ln;
    c = ch_q.score_char;
    u = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    dig = c >= 8'h30 && c <= 8'h39;
    ph_d = ph_q; kind_d = kind_q; semi_d = semi_q; poct_d = poct_q;
    acc_d = acc_q; seen_d = seen_q; dot_d = dot_q; oct_d = oct_q;
    dlen_d = dlen_q; tempo_d = tempo_q; jobs_d = '0; njobs_d = 2'd0;
    ext = 1'b0; cont = 1'b1; v = '0; ln = '0;
    for (int k = 0; k < 2; k++) begin
      // k=0: character, k=1: end-of-score flush
      if (k == 1 && !ch_q.end_of_score) break;
      if (k == 0 && (ph_d == PH_OCT || ph_d == PH_LEN || ph_d == PH_TMP) && dig) begin
        v = 20'(acc_d) * 20'd10 + 20'(c - 8'h30);
        acc_d = v > 20'd65535 ? 16'hffff : v[15:0];
        seen_d = 1'b1; cont = 1'b0;
      end else if (k == 1 && (ph_d == PH_OCT || ph_d == PH_LEN || ph_d == PH_TMP) ||
                   k == 0 && (ph_d == PH_OCT || ph_d == PH_LEN || ph_d == PH_TMP)) begin
        if (seen_d) begin
          if (ph_d == PH_OCT) oct_d = acc_d > 16'd8 ? 4'd8 : acc_d[3:0];
          else if (ph_d == PH_LEN)
            dlen_d = acc_d < 16'd1 ? 7'd1 : (acc_d > 16'd64 ? 7'd64 : acc_d[6:0]);
          else tempo_d = acc_d < 16'd20 ? 10'd20 : (acc_d > 16'd1023 ? 10'd1023 : acc_d[9:0]);
        end
        kind_d = PK_NONE; semi_d = '0; poct_d = '0; acc_d = '0; seen_d = 1'b0;
        dot_d = '0; ph_d = PH_IDLE;
      end else begin
        ext = 1'b0;
        if (k == 0 && ph_d == PH_ACC) begin
          ph_d = PH_NUM;
          if (c == 8'h23 || c == 8'h2b) begin
            if (semi_d >= 4'd11) begin semi_d = '0; poct_d = poct_d + 4'd1; end
            else semi_d = semi_d + 4'd1;
            ext = 1'b1;
          end else if (c == 8'h2d) begin
            if (semi_d == 4'd0) begin semi_d = 4'd11; poct_d = poct_d - 4'd1; end
            else semi_d = semi_d - 4'd1;
            ext = 1'b1;
          end
        end
        if (k == 0 && !ext && ph_d == PH_NUM) begin
          if (dig) begin
            v = 20'(acc_d) * 20'd10 + 20'(c - 8'h30);
            acc_d = v > 20'd65535 ? 16'hffff : v[15:0];
            seen_d = 1'b1; ext = 1'b1;
          end else if (c == 8'h2e) begin
            ph_d = PH_DOTS; dot_d = 4'd1; ext = 1'b1;
          end
        end else if (k == 0 && !ext && ph_d == PH_DOTS && c == 8'h2e) begin
          if (dot_d < 4'd15) dot_d = dot_d + 4'd1;
          ext = 1'b1;
        end
        if (ext) cont = 1'b0;
        else begin
          if ((ph_d == PH_NUM || ph_d == PH_DOTS || ph_d == PH_ACC) && kind_d != PK_NONE) begin
            ln = seen_d ? (acc_d < 16'd1 ? 7'd1 : (acc_d > 16'd64 ? 7'd64 : acc_d[6:0]))
                        : dlen_d;
            jobs_d[njobs_d[0]] = '{is_note: kind_d == PK_NOTE, semi: semi_d,
                                   octp1: poct_d, len: ln, tempo: tempo_d, dots: dot_d};
            njobs_d = njobs_d + 2'd1;
          end
          kind_d = PK_NONE; semi_d = '0; poct_d = '0; acc_d = '0; seen_d = 1'b0;
          dot_d = '0; ph_d = PH_IDLE;
        end
      end
      if (k == 0 && cont) begin
        priority if (u == 8'h4f) ph_d = PH_OCT;
        else if (u == 8'h4c) ph_d = PH_LEN;
        else if (u == 8'h54) ph_d = PH_TMP;
        else if (u == 8'h3e) begin if (oct_d < 4'd8) oct_d = oct_d + 4'd1; end
        else if (u == 8'h3c) begin if (oct_d > 4'd0) oct_d = oct_d - 4'd1; end
        else if (u == 8'h50 || u == 8'h52) begin kind_d = PK_REST; ph_d = PH_NUM; end
        else if (u >= 8'h41 && u <= 8'h47) begin
          kind_d = PK_NOTE;
          semi_d = letter_semi(3'(u - 8'h41));
          poct_d = (oct_d > 4'd8 ? 4'd8 : oct_d) + 4'd1;
          ph_d = PH_ACC;
        end
      end
      if (k == 1) begin
        ph_d = PH_IDLE; kind_d = PK_NONE; semi_d = '0; poct_d = '0; acc_d = '0;
        seen_d = 1'b0; dot_d = '0; oct_d = 4'd4; dlen_d = 7'd4; tempo_d = 10'd120;
      end
    end
  end

  mmnp_note_unit u_note (
    .clk_i, .rst_ni,
    .start_i(start),
    .job_i(jobs_q[jidx_q[0]]),
    .done_o(done),
    .freq_o(fr),
    .dur_o(du)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PARSE;
      ST_PARSE: state_d = (njobs_d != 2'd0) ? ST_DIV : ST_IDLE;
      ST_DIV:   state_d = ST_DOTS;
      ST_DOTS:  if (done) state_d = ST_EMIT;
      ST_EMIT:  if (!out_v_q || out_ready_i)
                  state_d = (jidx_q + 2'd1 < njobs_q) ? ST_DIV : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = state_q == ST_IDLE;
    start = state_q == ST_DIV;
    jidx_d = jidx_q;
    out_v_d = out_v_q && !out_ready_i;
    out_d = out_q;
    if (state_q == ST_PARSE) jidx_d = 2'd0;
    if (state_q == ST_EMIT && (!out_v_q || out_ready_i)) begin
      out_v_d = 1'b1;
      out_d = '{freq_hz: fr, duration_ms: du, last_of_run: jidx_q + 2'd1 >= njobs_q};
      jidx_d = jidx_q + 2'd1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ph_q <= PH_IDLE; kind_q <= PK_NONE;
      semi_q <= '0; poct_q <= '0; acc_q <= '0; seen_q <= 1'b0; dot_q <= '0;
      oct_q <= 4'd4; dlen_q <= 7'd4; tempo_q <= 10'd120;
      njobs_q <= '0; jidx_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      jidx_q <= jidx_d;
      out_v_q <= out_v_d;
      if (state_q == ST_PARSE) begin
        ph_q <= ph_d; kind_q <= kind_d; semi_q <= semi_d; poct_q <= poct_d;
        acc_q <= acc_d; seen_q <= seen_d; dot_q <= dot_d; oct_q <= oct_d;
        dlen_q <= dlen_d; tempo_q <= tempo_d; njobs_q <= njobs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) ch_q <= in_data_i;
    if (state_q == ST_PARSE) jobs_q <= jobs_d;
    out_q <= out_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !start) else $error("double start");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o)) else $error("output changed");

endmodule
